// ===== rtl/register_poll_spin_detector_unit_macros.svh =====
// Assertion macros for the spin detector checker.
`ifndef REGISTER_POLL_SPIN_DETECTOR_UNIT_MACROS_SVH
`define REGISTER_POLL_SPIN_DETECTOR_UNIT_MACROS_SVH

// Same-cycle implication.
`define RPSD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spin detector check failed");

// Next-cycle implication.
`define RPSD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spin detector check failed");

`endif

// ===== rtl/rpsd_pkg.sv =====
package rpsd_pkg;

    typedef enum logic [1:0] {
        CMD_READ   = 2'd0,
        CMD_ANCHOR = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    localparam logic [7:0]  NO_ADDR      = 8'hFF;
    localparam logic [31:0] U32_MAX      = 32'hFFFF_FFFF;
    localparam logic [31:0] BUDGET_RESET = 32'd1000000;

    // Per-request controls broadcast along the window cells
    typedef struct packed {
        logic rd;
        logic miss;
        logic full;
    } cell_ctrl_t;

endpackage

// ===== rtl/rpsd_cell.sv =====
module rpsd_cell #(
    parameter int IDX    = 0,
    parameter int FILL_W = 2
) (
    input  logic                    clk,
    input  rpsd_pkg::cell_ctrl_t    ctrl,
    input  logic [FILL_W-1:0]       fill,
    input  logic [7:0]              addr,
    input  logic                    hit_in,
    output logic                    hit_out
);

    logic [7:0] entry_reg;
    logic       entry_next;
    logic       active;

    assign active  = FILL_W'(IDX) < fill;
    assign hit_out = hit_in | (active && (entry_reg == addr));

    // append at the fill point, or restart the window in slot 0
    assign entry_next = ctrl.rd && ctrl.miss &&
                        ((fill == FILL_W'(IDX)) || (ctrl.full && (IDX == 0)));

    always_ff @(posedge clk)
    begin
        if (entry_next)
        begin
            entry_reg <= addr;
        end
    end

endmodule

// ===== rtl/register_poll_spin_detector_unit.sv =====
// Channel   Direction  Handshake            Payload
// request   in         in_valid / in_stall  cmd, addr, now_us, reset_busy
// result    out        out_valid/ out_stall trip_now, episode_reads, trip_total,
//                                           trip_reads, trip_addr
// config    in         cfg_wen              cfg_wdata (budget_us)
//
// One request per cycle unless stalled; each result appears the cycle after its
// request. The window compare chain, start-time select and elapsed-time compare
// are combinational. in_stall rises only while a result is held by out_stall.
// rst_n clears all control and statistics state at once; no clearing pass.
module register_poll_spin_detector_unit #(
    parameter int WINDOW_SLOTS = 3
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [7:0]  addr,
    input  logic [31:0] now_us,
    input  logic        reset_busy,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        trip_now,
    output logic [31:0] episode_reads,
    output logic [31:0] trip_total,
    output logic [31:0] trip_reads,
    output logic [7:0]  trip_addr,
    input  logic        cfg_wen,
    input  logic [31:0] cfg_wdata
);

    localparam int FILL_W = $clog2(WINDOW_SLOTS + 1);

    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [31:0]       count_reg, count_next;
    logic [31:0]       start_reg, start_next;
    logic              latched_reg, latched_next;
    logic [31:0]       trips_reg, trips_next;
    logic [31:0]       lreads_reg, lreads_next;
    logic [7:0]        laddr_reg, laddr_next;
    logic [31:0]       budget_reg;
    logic              out_valid_reg;
    logic              trip_now_reg, trip_now_next;

    logic                 accept;
    logic                 full;
    logic                 miss;
    logic [WINDOW_SLOTS:0] hit_chain;
    logic [31:0]          base_count;
    logic [31:0]          bumped_count;
    logic [31:0]          read_start;
    logic [31:0]          elapsed;
    logic                 over;
    rpsd_pkg::cell_ctrl_t ctrl;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    assign full      = fill_reg == FILL_W'(WINDOW_SLOTS);
    assign miss      = !hit_chain[WINDOW_SLOTS];
    assign ctrl.rd   = accept && (cmd == rpsd_pkg::CMD_READ) && !reset_busy && !latched_reg;
    assign ctrl.miss = miss;
    assign ctrl.full = full;

    assign hit_chain[0] = 1'b0;

    for (genvar g = 0; g < WINDOW_SLOTS; g++)
    begin : g_cell
        rpsd_cell #(
            .IDX    (g),
            .FILL_W (FILL_W)
        ) u_cell (
            .clk     (clk),
            .ctrl    (ctrl),
            .fill    (fill_reg),
            .addr    (addr),
            .hit_in  (hit_chain[g]),
            .hit_out (hit_chain[g+1])
        );
    end

    assign base_count   = (miss && full) ? 32'd0 : count_reg;
    assign bumped_count = (base_count == rpsd_pkg::U32_MAX) ? base_count : base_count + 32'd1;
    assign read_start   = (miss && (full || (fill_reg == '0))) ? now_us : start_reg;
    assign elapsed      = now_us - read_start;
    assign over         = elapsed > budget_reg;

    always_comb
    begin
        fill_next     = fill_reg;
        count_next    = count_reg;
        start_next    = start_reg;
        latched_next  = latched_reg;
        trips_next    = trips_reg;
        lreads_next   = lreads_reg;
        laddr_next    = laddr_reg;
        trip_now_next = trip_now_reg;
        if (accept)
        begin
            trip_now_next = 1'b0;
            case (cmd)
                rpsd_pkg::CMD_READ:
                begin
                    if (ctrl.rd)
                    begin
                        if (miss)
                        begin
                            fill_next = full ? FILL_W'(1) : fill_reg + FILL_W'(1);
                        end
                        count_next = bumped_count;
                        start_next = read_start;
                        if (over)
                        begin
                            trip_now_next = 1'b1;
                            latched_next  = 1'b1;
                            trips_next    = (trips_reg == rpsd_pkg::U32_MAX) ?
                                            trips_reg : trips_reg + 32'd1;
                            lreads_next   = bumped_count;
                            laddr_next    = addr;
                        end
                    end
                end
                rpsd_pkg::CMD_ANCHOR:
                begin
                    fill_next    = '0;
                    count_next   = '0;
                    latched_next = 1'b0;
                    start_next   = now_us;
                end
                rpsd_pkg::CMD_CLEAR:
                begin
                    fill_next    = '0;
                    count_next   = '0;
                    latched_next = 1'b0;
                    start_next   = now_us;
                    trips_next   = '0;
                    lreads_next  = '0;
                    laddr_next   = rpsd_pkg::NO_ADDR;
                end
                default:
                begin
                    fill_next = fill_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            count_reg     <= '0;
            start_reg     <= '0;
            latched_reg   <= 1'b0;
            trips_reg     <= '0;
            lreads_reg    <= '0;
            laddr_reg     <= rpsd_pkg::NO_ADDR;
            budget_reg    <= rpsd_pkg::BUDGET_RESET;
            out_valid_reg <= 1'b0;
            trip_now_reg  <= 1'b0;
        end
        else
        begin
            fill_reg     <= fill_next;
            count_reg    <= count_next;
            start_reg    <= start_next;
            latched_reg  <= latched_next;
            trips_reg    <= trips_next;
            lreads_reg   <= lreads_next;
            laddr_reg    <= laddr_next;
            trip_now_reg <= trip_now_next;
            if (cfg_wen)
            begin
                budget_reg <= cfg_wdata;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // state only moves on an accepted request, so it doubles as the held result
    assign out_valid     = out_valid_reg;
    assign trip_now      = trip_now_reg;
    assign episode_reads = count_reg;
    assign trip_total    = trips_reg;
    assign trip_reads    = lreads_reg;
    assign trip_addr     = laddr_reg;

endmodule

// ===== rtl/rpsd_checker.sv =====
`include "register_poll_spin_detector_unit_macros.svh"

module rpsd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [1:0]  cmd,
    input logic        out_valid,
    input logic        out_stall,
    input logic        trip_now,
    input logic [31:0] episode_reads,
    input logic [31:0] trip_total,
    input logic [7:0]  trip_addr
);

    logic accept;
    logic anchor_acc;
    logic clear_acc;

    assign accept     = in_valid && !in_stall;
    assign anchor_acc = accept && (cmd == rpsd_pkg::CMD_ANCHOR);
    assign clear_acc  = accept && (cmd == rpsd_pkg::CMD_CLEAR);

    `RPSD_ASSERT_NEXT(a_held_result, out_valid && out_stall, out_valid)
    `RPSD_ASSERT_NEXT(a_result_follows, accept, out_valid)
    `RPSD_ASSERT_NOW(a_trip_counted, out_valid && trip_now, trip_total != 32'd0)
    `RPSD_ASSERT_NEXT(a_anchor_clears, anchor_acc, episode_reads == 32'd0 && !trip_now)
    `RPSD_ASSERT_NEXT(a_clear_stats, clear_acc, trip_total == 32'd0 && trip_addr == rpsd_pkg::NO_ADDR)

endmodule

bind register_poll_spin_detector_unit rpsd_checker u_rpsd_checker (.*);

// ===== test/tb_register_poll_spin_detector_unit.sv =====
`timescale 1ns / 1ps

module tb_register_poll_spin_detector_unit;

    localparam int         SPIN_SLOTS  = 3;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic        trip;
        logic [31:0] reads;
        logic [31:0] total;
        logic [31:0] trip_rd;
        logic [7:0]  trip_ad;
    } spin_outcome_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  cmd;
    logic [7:0]  addr;
    logic [31:0] now_us;
    logic        reset_busy;
    logic        out_valid;
    logic        out_stall;
    logic        trip_now;
    logic [31:0] episode_reads;
    logic [31:0] trip_total;
    logic [31:0] trip_reads;
    logic [7:0]  trip_addr;
    logic        cfg_wen;
    logic [31:0] cfg_wdata;

    // predicted block state
    logic [7:0]  win_addr [SPIN_SLOTS];
    int          win_fill;
    logic [31:0] poll_reads;
    logic [31:0] win_start_us;
    logic        spin_latched;
    logic [31:0] trip_count_q;
    logic [31:0] trip_reads_q;
    logic [7:0]  trip_addr_q;
    logic [31:0] budget_q;

    spin_outcome_t expected_outcomes [$];
    spin_outcome_t want;

    int          gap_pct;
    int          stall_pct;
    int          mismatch_count;
    int          requests_sent;
    int          outcomes_checked;
    int          trips_seen;
    int          budgets_written;
    int          cycle_count;
    logic [31:0] sim_clock_us;

    register_poll_spin_detector_unit #(
        .WINDOW_SLOTS(SPIN_SLOTS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .addr         (addr),
        .now_us       (now_us),
        .reset_busy   (reset_busy),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .trip_now     (trip_now),
        .episode_reads(episode_reads),
        .trip_total   (trip_total),
        .trip_reads   (trip_reads),
        .trip_addr    (trip_addr),
        .cfg_wen      (cfg_wen),
        .cfg_wdata    (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("mismatch on %s at cycle %0d: got %0h, expected %0h",
                 field, cycle_count, got, exp_val);
        mismatch_count++;
    endtask

    task automatic predict_spin_outcome(input logic [1:0] c, input logic [7:0] a,
                                        input logic [31:0] t, input logic busy);
        spin_outcome_t r;
        logic          hit;
        logic [31:0]   elapsed;
        r.trip = 1'b0;
        hit    = 1'b0;
        case (c)
            rpsd_pkg::CMD_READ:
            begin
                if (!busy && !spin_latched)
                begin
                    for (int i = 0; i < SPIN_SLOTS; i++)
                        if (i < win_fill && win_addr[i] == a)
                            hit = 1'b1;
                    if (!hit)
                    begin
                        if (win_fill < SPIN_SLOTS)
                        begin
                            if (win_fill == 0)
                                win_start_us = t;
                            win_addr[win_fill] = a;
                            win_fill++;
                        end
                        else
                        begin
                            // full window: episode restarts on this address
                            win_addr[0]  = a;
                            win_fill     = 1;
                            poll_reads   = '0;
                            win_start_us = t;
                        end
                    end
                    if (poll_reads != rpsd_pkg::U32_MAX)
                        poll_reads++;
                    elapsed = t - win_start_us;
                    if (elapsed > budget_q)
                    begin
                        r.trip       = 1'b1;
                        spin_latched = 1'b1;
                        if (trip_count_q != rpsd_pkg::U32_MAX)
                            trip_count_q++;
                        trip_reads_q = poll_reads;
                        trip_addr_q  = a;
                    end
                end
            end
            rpsd_pkg::CMD_ANCHOR, rpsd_pkg::CMD_CLEAR:
            begin
                if (c == rpsd_pkg::CMD_CLEAR)
                begin
                    trip_count_q = '0;
                    trip_reads_q = '0;
                    trip_addr_q  = rpsd_pkg::NO_ADDR;
                end
                win_fill     = 0;
                poll_reads   = '0;
                spin_latched = 1'b0;
                win_start_us = t;
            end
            default:
            begin
            end
        endcase
        r.reads   = poll_reads;
        r.total   = trip_count_q;
        r.trip_rd = trip_reads_q;
        r.trip_ad = trip_addr_q;
        expected_outcomes.push_back(r);
    endtask

    task automatic send_request(input logic [1:0] c, input logic [7:0] a,
                                input logic [31:0] t, input logic busy);
        if (gap_pct != 0 && $urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < gap_pct);
        end
        in_valid   <= 1'b1;
        cmd        <= c;
        addr       <= a;
        now_us     <= t;
        reset_busy <= busy;
        do
            @(posedge clk);
        while (in_stall);
        predict_spin_outcome(c, a, t, busy);
        requests_sent++;
    endtask

    task automatic drain_outcomes;
        in_valid <= 1'b0;
        while (expected_outcomes.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_budget(input logic [31:0] value);
        drain_outcomes();
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        budget_q = value;
        budgets_written++;
        cfg_wen <= 1'b0;
    endtask

    task automatic test_window_episodes;
        send_request(rpsd_pkg::CMD_READ, 8'h00, 32'd0, 1'b0);
        send_request(rpsd_pkg::CMD_READ, 8'hFF, 32'd10, 1'b0);
        send_request(rpsd_pkg::CMD_READ, 8'h00, 32'd20, 1'b0);
        send_request(rpsd_pkg::CMD_READ, 8'h5A, 32'd30, 1'b0);
        send_request(rpsd_pkg::CMD_READ, 8'hA5, 32'd40, 1'b0);
        send_request(rpsd_pkg::CMD_ANCHOR, 8'h00, 32'd50, 1'b0);
    endtask

    task automatic test_ignored_requests;
        send_request(rpsd_pkg::CMD_READ, 8'h12, 32'd100, 1'b1);
        send_request(CMD_UNUSED, 8'h34, 32'd200, 1'b0);
        send_request(rpsd_pkg::CMD_ANCHOR, 8'h56, 32'd300, 1'b1);
    endtask

    task automatic test_trip_and_latch;
        send_request(rpsd_pkg::CMD_READ, 8'h20, 32'd1000, 1'b0);
        send_request(rpsd_pkg::CMD_READ, 8'h21, 32'd1001000, 1'b0);
        send_request(rpsd_pkg::CMD_READ, 8'h20, 32'd1001001, 1'b0);
        send_request(rpsd_pkg::CMD_READ, 8'h22, 32'd2000000, 1'b0);
        send_request(rpsd_pkg::CMD_ANCHOR, 8'h00, 32'd2000001, 1'b1);
        send_request(rpsd_pkg::CMD_READ, 8'h30, 32'd2000002, 1'b0);
        send_request(rpsd_pkg::CMD_CLEAR, 8'h00, 32'd2000003, 1'b0);
    endtask

    task automatic test_time_wrap;
        logic [31:0] base;
        base = 32'hFFFF_FFF0;
        send_request(rpsd_pkg::CMD_READ, 8'h40, base, 1'b0);
        send_request(rpsd_pkg::CMD_READ, 8'h40, 32'h0000_0010, 1'b0);
        send_request(rpsd_pkg::CMD_READ, 8'h41, base + 32'd1000001, 1'b0);
        send_request(rpsd_pkg::CMD_CLEAR, 8'hFF, 32'hFFFF_FFFF, 1'b1);
    endtask

    task automatic test_budget_extremes;
        write_budget(32'd0);
        send_request(rpsd_pkg::CMD_READ, 8'h77, 32'd5, 1'b0);
        send_request(rpsd_pkg::CMD_READ, 8'h77, 32'd5, 1'b0);
        send_request(rpsd_pkg::CMD_READ, 8'h78, 32'd6, 1'b0);
        write_budget(32'hFFFF_FFFF);
        send_request(rpsd_pkg::CMD_ANCHOR, 8'h00, 32'd0, 1'b0);
        send_request(rpsd_pkg::CMD_READ, 8'h01, 32'd0, 1'b0);
        send_request(rpsd_pkg::CMD_READ, 8'h01, 32'hFFFF_FFFF, 1'b0);
    endtask

    task automatic test_random_polling(input int n);
        logic [7:0]  pool [4];
        int          pool_sz;
        int          useful;
        int          roll;
        logic [31:0] step_max;
        logic [7:0]  a;
        logic        busy;
        bit          fresh;
        step_max = (budget_q >> 3) + 32'd2;
        useful   = 0;
        fresh    = 1'b1;
        while (useful < n)
        begin
            if (fresh)
            begin
                pool_sz = $urandom_range(4, 1);
                foreach (pool[j])
                    pool[j] = 8'($urandom);
                fresh = 1'b0;
            end
            roll = $urandom_range(99);
            sim_clock_us += $urandom_range(step_max);
            if ((spin_latched && roll < 30) || roll < 3)
            begin
                send_request(rpsd_pkg::CMD_ANCHOR, 8'($urandom), sim_clock_us,
                             1'($urandom));
                fresh = 1'b1;
                useful++;
            end
            else if (roll < 5)
            begin
                send_request(rpsd_pkg::CMD_CLEAR, 8'($urandom), sim_clock_us,
                             1'($urandom));
                fresh = 1'b1;
                useful++;
            end
            else if (roll < 6)
            begin
                send_request(CMD_UNUSED, 8'($urandom), $urandom, 1'($urandom));
                useful++;
            end
            else
            begin
                busy = ($urandom_range(19) == 0);
                if (roll < 9)
                    sim_clock_us = $urandom;
                a = (roll < 14) ? 8'($urandom) : pool[$urandom_range(pool_sz - 1)];
                useful++;
                send_request(rpsd_pkg::CMD_READ, a, sim_clock_us, busy);
            end
        end
    endtask

    always @(posedge clk)
        out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_outcomes.size() == 0)
                report_mismatch("unexpected result", 32'd0, 32'd0);
            else
            begin
                want = expected_outcomes.pop_front();
                if (trip_now !== want.trip)
                    report_mismatch("trip_now", 32'(trip_now), 32'(want.trip));
                if (episode_reads !== want.reads)
                    report_mismatch("episode_reads", episode_reads, want.reads);
                if (trip_total !== want.total)
                    report_mismatch("trip_total", trip_total, want.total);
                if (trip_reads !== want.trip_rd)
                    report_mismatch("trip_reads", trip_reads, want.trip_rd);
                if (trip_addr !== want.trip_ad)
                    report_mismatch("trip_addr", 32'(trip_addr), 32'(want.trip_ad));
                if (want.trip)
                    trips_seen++;
                outcomes_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timed out with %0d results outstanding", expected_outcomes.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] budgets [5];
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        cmd        <= rpsd_pkg::CMD_READ;
        addr       <= '0;
        now_us     <= '0;
        reset_busy <= 1'b0;
        cfg_wen    <= 1'b0;
        cfg_wdata  <= '0;
        gap_pct          = 0;
        stall_pct        = 0;
        mismatch_count   = 0;
        requests_sent    = 0;
        outcomes_checked = 0;
        trips_seen       = 0;
        budgets_written  = 0;
        sim_clock_us     = '0;
        foreach (win_addr[i])
            win_addr[i] = '0;
        win_fill     = 0;
        poll_reads   = '0;
        win_start_us = '0;
        spin_latched = 1'b0;
        trip_count_q = '0;
        trip_reads_q = '0;
        trip_addr_q  = rpsd_pkg::NO_ADDR;
        budget_q     = rpsd_pkg::BUDGET_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_window_episodes();
        test_ignored_requests();
        test_trip_and_latch();
        test_time_wrap();
        test_budget_extremes();

        budgets[0] = rpsd_pkg::BUDGET_RESET;
        budgets[1] = 32'd0;
        budgets[2] = 32'hFFFF_FFFF;
        budgets[3] = 32'd200;
        // idling phases: none, sender gaps, receiver stalls, both light
        for (int phase = 0; phase < 4; phase++)
        begin
            drain_outcomes();
            gap_pct   = (phase == 1) ? 78 : (phase == 3) ? 8 : 0;
            stall_pct = (phase == 2) ? 78 : (phase == 3) ? 8 : 0;
            budgets[4] = $urandom_range(5000, 1);
            foreach (budgets[b])
            begin
                write_budget(budgets[b]);
                test_random_polling(45);
            end
        end

        drain_outcomes();
        $display("%0d requests sent, %0d results checked, %0d trips seen",
                 requests_sent, outcomes_checked, trips_seen);
        $display("%0d budget writes across four idling phases, %0d mismatches",
                 budgets_written, mismatch_count);
        if (mismatch_count == 0 && expected_outcomes.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rpsd_pkg.sv
rtl/rpsd_cell.sv
rtl/register_poll_spin_detector_unit.sv
rtl/rpsd_checker.sv
test/tb_register_poll_spin_detector_unit.sv
